// ===== design/ahs_pkg.sv =====
package ahs_pkg;

  localparam int CNT_W  = 21;
  localparam int TGT_W  = 24;
  localparam int RATE_W = 20;
  localparam int RATE_SCALE = 10;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_RESET  = 2'd3;

  localparam logic [1:0] MODE_SENSORLESS = 2'd0;
  localparam logic [1:0] MODE_HYBRID     = 2'd2;

  localparam logic [1:0] FLT_NONE      = 2'd0;
  localparam logic [1:0] FLT_CANCELLED = 2'd1;
  localparam logic [1:0] FLT_TRAVEL    = 2'd2;
  localparam logic [1:0] FLT_TIMEOUT   = 2'd3;

  localparam logic [2:0] SEQ_IDLE     = 3'd0;
  localparam logic [2:0] SEQ_HOMING   = 3'd1;
  localparam logic [2:0] SEQ_RETREAT  = 3'd2;
  localparam logic [2:0] SEQ_COMPLETE = 3'd3;
  localparam logic [2:0] SEQ_ERROR    = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_HOMING_MODE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOMING_SPEED     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RETREAT_SPEED    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RETREAT_DISTANCE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRAVEL       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE         = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT           = 3'd6;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_HOMING   = 5'b00010,
    PH_RETREAT  = 5'b00100,
    PH_COMPLETE = 5'b01000,
    PH_ERROR    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic        stall_detected;
    logic        stall_enabled;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  sequencer_state;
    logic        busy_res;
    logic        finished;
    logic        succeeded;
    logic [1:0]  fault_code;
    logic [19:0] home_position;
    logic        step_pulse;
    logic        move_direction;
    logic [19:0] step_rate;
    logic [31:0] elapsed_ms;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        homing_mode;
    logic [RATE_W-1:0] homing_rate;
    logic [RATE_W-1:0] retreat_rate;
    logic [TGT_W-1:0]  retreat_target;
    logic [TGT_W-1:0]  travel_target;
    logic [15:0]       debounce_ms;
    logic              invert_direction;
  } cfg_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:     code = SEQ_IDLE;
      PH_HOMING:   code = SEQ_HOMING;
      PH_RETREAT:  code = SEQ_RETREAT;
      PH_COMPLETE: code = SEQ_COMPLETE;
      PH_ERROR:    code = SEQ_ERROR;
      default:     code = SEQ_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== design/ahs_cfg.sv =====
module ahs_cfg import ahs_pkg::*; #(
  parameter int STEPS_PER_MM = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  localparam logic [TGT_W-1:0] RETREAT_TGT_RST = TGT_W'(5 * STEPS_PER_MM);
  localparam logic [TGT_W-1:0] TRAVEL_TGT_RST  = TGT_W'(100 * STEPS_PER_MM);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.homing_mode      <= MODE_SENSORLESS;
      cfg_r.homing_rate      <= RATE_W'(100 * RATE_SCALE);
      cfg_r.retreat_rate     <= RATE_W'(50 * RATE_SCALE);
      cfg_r.retreat_target   <= RETREAT_TGT_RST;
      cfg_r.travel_target    <= TRAVEL_TGT_RST;
      cfg_r.debounce_ms      <= 16'd10;
      cfg_r.invert_direction <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_HOMING_MODE:      cfg_r.homing_mode <= cfg_wdata[1:0];
        REG_HOMING_SPEED:     cfg_r.homing_rate <=
                                RATE_W'(32'(cfg_wdata) * 32'(RATE_SCALE));
        REG_RETREAT_SPEED:    cfg_r.retreat_rate <=
                                RATE_W'(32'(cfg_wdata) * 32'(RATE_SCALE));
        REG_RETREAT_DISTANCE: cfg_r.retreat_target <=
                                TGT_W'(32'(cfg_wdata[13:0]) * 32'(STEPS_PER_MM));
        REG_MAX_TRAVEL:       cfg_r.travel_target <=
                                TGT_W'(32'(cfg_wdata[13:0]) * 32'(STEPS_PER_MM));
        REG_DEBOUNCE:         cfg_r.debounce_ms <= cfg_wdata;
        REG_INVERT:           cfg_r.invert_direction <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/ahs_core.sv =====
module ahs_core import ahs_pkg::*; #(
  parameter int TIMEOUT_MS = 30000
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]  retreat_r, retreat_nxt;
  logic [31:0]       start_r, start_nxt;
  logic              armed_r, armed_nxt;
  logic [31:0]       db_start_r, db_start_nxt;
  logic [CNT_W-1:0]  trig_pos_r, trig_pos_nxt;
  logic              ok_r, ok_nxt;
  logic [1:0]        fault_r, fault_nxt;

  logic              busy;
  logic              run_home;
  logic              run_retreat;
  logic              triggered;
  logic              pulse;
  logic              dir;
  logic [RATE_W-1:0] rate;

  always_comb begin
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    retreat_nxt  = retreat_r;
    start_nxt    = start_r;
    armed_nxt    = armed_r;
    db_start_nxt = db_start_r;
    trig_pos_nxt = trig_pos_r;
    ok_nxt       = ok_r;
    fault_nxt    = fault_r;
    busy         = (phase_r == PH_HOMING) || (phase_r == PH_RETREAT);
    run_home     = 1'b0;
    run_retreat  = 1'b0;
    triggered    = 1'b0;
    pulse        = 1'b0;
    dir          = 1'b0;
    rate         = '0;

    case (item.operation)
      OP_START: begin
        if (!busy) begin
          phase_nxt    = PH_HOMING;
          armed_nxt    = 1'b0;
          db_start_nxt = '0;
          ok_nxt       = 1'b0;
          fault_nxt    = FLT_NONE;
          trig_pos_nxt = '0;
          start_nxt    = item.now_ms;
          step_nxt     = '0;
          retreat_nxt  = '0;
          run_home     = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (busy) begin
          phase_nxt = PH_IDLE;
          ok_nxt    = 1'b0;
          fault_nxt = FLT_CANCELLED;
        end
      end
      OP_RESET: begin
        phase_nxt    = PH_IDLE;
        armed_nxt    = 1'b0;
        db_start_nxt = '0;
        ok_nxt       = 1'b0;
        fault_nxt    = FLT_NONE;
        trig_pos_nxt = '0;
        step_nxt     = '0;
        retreat_nxt  = '0;
      end
      default: begin
        run_home    = (phase_r == PH_HOMING);
        run_retreat = (phase_r == PH_RETREAT);
      end
    endcase

    if (run_home) begin
      dir  = ~cfg.invert_direction;
      rate = cfg.homing_rate;
      if (((cfg.homing_mode == MODE_SENSORLESS) || (cfg.homing_mode == MODE_HYBRID))
          && item.stall_enabled) begin
        if (item.stall_detected) begin
          if (!armed_nxt) begin
            armed_nxt    = 1'b1;
            db_start_nxt = item.now_ms;
          end
          triggered = (item.now_ms - db_start_nxt) >= 32'(cfg.debounce_ms);
        end else begin
          armed_nxt = 1'b0;
        end
      end
      if (triggered) begin
        trig_pos_nxt = step_nxt;
        phase_nxt    = PH_RETREAT;
        armed_nxt    = 1'b0;
        retreat_nxt  = '0;
      end else if ((TGT_W'(step_nxt) >= cfg.travel_target) || (&step_nxt)) begin
        phase_nxt = PH_ERROR;
        ok_nxt    = 1'b0;
        fault_nxt = FLT_TRAVEL;
      end else if ((item.now_ms - start_nxt) > 32'(TIMEOUT_MS)) begin
        phase_nxt = PH_ERROR;
        ok_nxt    = 1'b0;
        fault_nxt = FLT_TIMEOUT;
      end else begin
        step_nxt = step_nxt + 1'b1;
        pulse    = 1'b1;
      end
    end

    if (run_retreat) begin
      dir  = cfg.invert_direction;
      rate = cfg.retreat_rate;
      if ((TGT_W'(retreat_r) < cfg.retreat_target) && !(&retreat_r)) begin
        retreat_nxt = retreat_r + 1'b1;
        pulse       = 1'b1;
      end else begin
        phase_nxt = PH_COMPLETE;
        ok_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      step_r     <= '0;
      retreat_r  <= '0;
      start_r    <= '0;
      armed_r    <= 1'b0;
      db_start_r <= '0;
      trig_pos_r <= '0;
      ok_r       <= 1'b0;
      fault_r    <= FLT_NONE;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      retreat_r  <= retreat_nxt;
      start_r    <= start_nxt;
      armed_r    <= armed_nxt;
      db_start_r <= db_start_nxt;
      trig_pos_r <= trig_pos_nxt;
      ok_r       <= ok_nxt;
      fault_r    <= fault_nxt;
    end
  end

  always_comb begin
    result.sequencer_state = phase_code(phase_nxt);
    result.busy_res        = (phase_nxt == PH_HOMING) || (phase_nxt == PH_RETREAT);
    result.finished        = (phase_nxt == PH_COMPLETE) || (phase_nxt == PH_ERROR);
    result.succeeded       = ok_nxt;
    result.fault_code      = fault_nxt;
    result.home_position   = trig_pos_nxt[CNT_W-1] ? '1 : trig_pos_nxt[19:0];
    result.step_pulse      = pulse;
    result.move_direction  = dir;
    result.step_rate       = rate;
    result.elapsed_ms      = item.now_ms - start_nxt;
  end

endmodule

// ===== design/axis_homing_sequencer.sv =====
// Channel  Direction  Handshake                 Payload
// in_      input      in_valid / in_ready       in_data   (in_item_t)
// out_     output     out_valid / out_ready     out_data  (out_item_t)
// cfg_     input      cfg_wr_en                 cfg_addr, cfg_wdata
//
// Each beat is held in the input register and is loaded into the result register on
// an edge at which the result register is empty or being read, so one beat can be
// taken every cycle while out_ready does not stall the result register.
// The sequencer state is updated in the same edge that loads the result register.
// A stalled result register holds the input register; reset is synchronous and
// restores the register defaults and the idle phase.
module axis_homing_sequencer import ahs_pkg::*; #(
  parameter int STEPS_PER_MM = 100,
  parameter int TIMEOUT_MS   = 30000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  logic      advance;
  logic      step_en;
  cfg_t      cfg;
  out_item_t result;

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;
  assign step_en  = in_vld_r && advance;

  ahs_cfg #(
    .STEPS_PER_MM(STEPS_PER_MM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ahs_core #(
    .TIMEOUT_MS(TIMEOUT_MS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (step_en) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
